/* hdl/lsg_pkg.sv */
// Shared types and constants for the lane segment grouper.
// Used by lsg_ctrl, lsg_datapath and lane_segment_grouper_unit; depends on nothing.
package lsg_pkg;

  localparam int unsigned CORDIC_STEPS = 20;
  localparam int unsigned SQRT_BITS    = 13;
  localparam int unsigned MUL_STEPS    = 6;
  localparam logic signed [15:0] ANGLE_90 = 16'sd23040;
  localparam logic signed [25:0] Z_MAX    = 26'sd5898240;

  localparam logic [1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ANGLE_TOL  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_PREP,
    OP_MUL,
    OP_ITER_INIT,
    OP_ITER,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_MERGE,
    OP_APPEND,
    OP_EMIT_LOAD
  } lsg_op_t;

  typedef struct packed {
    lsg_op_t op;
  } lsg_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic iter_done;
    logic scan_end;
    logic match;
    logic last_entry;
    logic out_free;
  } lsg_status_t;

  function automatic logic [21:0] cordic_step_angle(input logic [4:0] i);
    logic [21:0] a;
    unique case (i)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

/* hdl/lsg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsg_ram #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 10
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/lsg_ctrl.sv */
// Sequencer for the lane segment grouper: issues at most one datapath operation per cycle.
// Depends on lsg_pkg.
module lsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  lsg_pkg::lsg_status_t sts,
  output lsg_pkg::lsg_cmd_t    cmd
);
  import lsg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_ITER_INIT, S_ITER, S_SCAN_START,
    S_SCAN_RD, S_SCAN_CHK, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = in_kind ? S_EMIT_RD : S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (sts.mul_done) state_nxt = S_ITER_INIT;
      end
      S_ITER_INIT: begin
        cmd.op    = OP_ITER_INIT;
        state_nxt = S_ITER;
      end
      S_ITER: begin
        cmd.op = OP_ITER;
        if (sts.iter_done) state_nxt = S_SCAN_START;
      end
      S_SCAN_START: begin
        cmd.op    = OP_SCAN_START;
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          cmd.op    = OP_APPEND;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.match) begin
          cmd.op    = OP_MERGE;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SCAN_NEXT;
          state_nxt = S_SCAN_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT_LOAD;
          state_nxt = sts.last_entry ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* hdl/lsg_datapath.sv */
// Datapath: configuration, coordinate prep, products, CORDIC angle, exact root
// distance, group table scan and result register. Depends on lsg_pkg and lsg_ram.
module lsg_datapath #(
  parameter int unsigned MAX_GROUPS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [14:0]          cfg_wdata,
  input  logic [47:0]          in_tdata,
  input  lsg_pkg::lsg_cmd_t    cmd,
  output lsg_pkg::lsg_status_t sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,
  output logic                 out_tuser,
  output logic                 out_tlast
);
  import lsg_pkg::*;

  localparam int unsigned CW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic [11:0] width_r, height_r;
  logic [14:0] tol_r;
  logic [11:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [12:0] x0_r, y0_r, x1_r;
  logic signed [13:0] dx_r, dy_r;
  logic special_r;
  logic [2:0] mstep_r;
  logic signed [27:0] t0_r, t1_r;
  logic [26:0] an_r;
  logic [53:0] nn_r;
  logic [27:0] sdx_r, s_r;
  logic [4:0]  iter_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [25:0] cz_r;
  logic [53:0] p_r;
  logic [40:0] q_r;
  logic [12:0] d_r;
  logic signed [15:0] ang_r;
  logic [12:0] dist_r;
  logic [CW-1:0] k_r, count_r;
  logic ovf_r;
  logic out_valid_r, out_last_r, out_ev_r, out_ovf_r;
  logic [5:0]  out_idx_r;
  logic signed [15:0] out_ang_r;
  logic [12:0] out_dist_r;

  // coordinate prep
  logic [11:0] ox;
  logic signed [13:0] x0c, y0c, x1c, y1c;
  assign ox  = {1'b0, width_r[11:1]};
  assign x0c = $signed({2'b0, sx_r}) - $signed({2'b0, ox});
  assign y0c = $signed({2'b0, height_r}) - $signed({2'b0, sy_r});
  assign x1c = $signed({2'b0, ex_r}) - $signed({2'b0, ox});
  assign y1c = $signed({2'b0, height_r}) - $signed({2'b0, ey_r});

  // products
  logic signed [27:0] dx_sq, dy_sq, diff;
  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;
  assign diff  = t0_r - t1_r;

  // cordic
  function automatic logic signed [33:0] shift_tz(input logic signed [33:0] v,
                                                  input logic [4:0] s);
    logic signed [33:0] r;
    if (v < 0) r = -((-v) >>> s);
    else       r = v >>> s;
    return r;
  endfunction

  logic signed [33:0] shx, shy;
  logic signed [25:0] step_a;
  logic [12:0] adx, ady;
  assign shx    = shift_tz(cx_r, iter_r);
  assign shy    = shift_tz(cy_r, iter_r);
  assign step_a = $signed({4'b0, cordic_step_angle(iter_r)});
  assign adx    = dx_r[13] ? 13'(-dx_r) : 13'(dx_r);
  assign ady    = dy_r[13] ? 13'(-dy_r) : 13'(dy_r);

  // root search
  logic [3:0]  sb;
  logic [55:0] cand;
  assign sb   = 4'(4'd12 - iter_r[3:0]);
  assign cand = 56'(p_r) + (56'(q_r) << (sb + 4'd1)) + (56'(s_r) << (2 * sb));

  // angle finish
  logic signed [25:0] zc, zr;
  logic [14:0] afq;
  logic signed [15:0] ang_c;
  logic [12:0] dist_c;
  logic [12:0] ax1;
  always_comb begin
    if (cz_r < 0)          zc = '0;
    else if (cz_r > Z_MAX) zc = Z_MAX;
    else                   zc = cz_r;
    zr  = zc + 26'sd128;
    afq = zr[22:8];
    ax1 = x1_r[12] ? 13'(-x1_r) : 13'(x1_r);
    if (special_r)        ang_c = ANGLE_90;
    else if (dy_r == '0)  ang_c = '0;
    else if (dx_r[13] != dy_r[13]) ang_c = -$signed({1'b0, afq});
    else                  ang_c = $signed({1'b0, afq});
    dist_c = special_r ? ax1 : d_r;
  end

  // table
  logic [28:0] rdata, wdata;
  logic [AW-1:0] waddr;
  logic we;
  logic signed [15:0] g_ang;
  logic [12:0] g_dist;
  logic signed [17:0] hi, lo, g_ext;
  logic full, count_zero;
  assign g_ang  = $signed(rdata[28:13]);
  assign g_dist = rdata[12:0];
  assign g_ext  = 18'(g_ang);
  assign hi     = 18'(ang_r) + $signed({3'b0, tol_r});
  assign lo     = 18'(ang_r) - $signed({3'b0, tol_r});
  assign full   = (count_r == CW'(MAX_GROUPS));
  assign count_zero = (count_r == '0);
  assign wdata  = {ang_r, dist_r};

  always_comb begin
    we    = 1'b0;
    waddr = k_r[AW-1:0];
    if (cmd.op == OP_MERGE) begin
      we = (g_dist > dist_r);
    end else if (cmd.op == OP_APPEND) begin
      we    = !full;
      waddr = count_r[AW-1:0];
    end
  end

  lsg_ram #(.WIDTH(29), .DEPTH(MAX_GROUPS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (k_r[AW-1:0]),
    .rdata (rdata)
  );

  assign sts.mul_done   = (mstep_r == 3'(MUL_STEPS - 1));
  assign sts.iter_done  = (iter_r == 5'(CORDIC_STEPS - 1));
  assign sts.scan_end   = (k_r == count_r);
  assign sts.match      = (g_ext < hi) && (g_ext > lo);
  assign sts.last_entry = count_zero || ((k_r + CW'(1)) == count_r);
  assign sts.out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 12'd480;
      height_r    <= 12'd640;
      tol_r       <= 15'd1280;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMG_WIDTH:  width_r  <= cfg_wdata[11:0];
          CFG_IMG_HEIGHT: height_r <= cfg_wdata[11:0];
          CFG_ANGLE_TOL:  tol_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.op == OP_APPEND) begin
        if (full) ovf_r <= 1'b1;
        else      count_r <= count_r + CW'(1);
      end
      if (cmd.op == OP_EMIT_LOAD) begin
        out_valid_r <= 1'b1;
        if (sts.last_entry) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        sx_r <= in_tdata[11:0];
        sy_r <= in_tdata[23:12];
        ex_r <= in_tdata[35:24];
        ey_r <= in_tdata[47:36];
        k_r  <= '0;
      end
      OP_PREP: begin
        x0_r      <= 13'(x0c);
        y0_r      <= 13'(y0c);
        x1_r      <= 13'(x1c);
        dx_r      <= x1c - x0c;
        dy_r      <= y1c - y0c;
        special_r <= (x1c == x0c) || (x1c == '0);
        mstep_r   <= '0;
      end
      OP_MUL: begin
        mstep_r <= mstep_r + 3'd1;
        unique case (mstep_r)
          3'd0: t0_r  <= y0_r * dx_r;
          3'd1: t1_r  <= x0_r * dy_r;
          3'd2: an_r  <= diff[27] ? 27'(-diff) : 27'(diff);
          3'd3: nn_r  <= an_r * an_r;
          3'd4: sdx_r <= dx_sq;
          default: s_r <= sdx_r + dy_sq;
        endcase
      end
      OP_ITER_INIT: begin
        cx_r   <= 34'(adx) <<< 16;
        cy_r   <= 34'(ady) <<< 16;
        cz_r   <= '0;
        p_r    <= '0;
        q_r    <= '0;
        d_r    <= '0;
        iter_r <= '0;
      end
      OP_ITER: begin
        iter_r <= iter_r + 5'd1;
        if (cy_r >= 0) begin
          cx_r <= cx_r + shy;
          cy_r <= cy_r - shx;
          cz_r <= cz_r + step_a;
        end else begin
          cx_r <= cx_r - shy;
          cy_r <= cy_r + shx;
          cz_r <= cz_r - step_a;
        end
        if (iter_r < 5'(SQRT_BITS) && cand <= 56'(nn_r)) begin
          p_r <= cand[53:0];
          q_r <= q_r + (41'(s_r) << sb);
          d_r <= d_r | (13'd1 << sb);
        end
      end
      OP_SCAN_START: begin
        ang_r  <= ang_c;
        dist_r <= dist_c;
        k_r    <= '0;
      end
      OP_SCAN_NEXT: k_r <= k_r + CW'(1);
      OP_EMIT_LOAD: begin
        k_r        <= k_r + CW'(1);
        out_idx_r  <= count_zero ? 6'd0 : 6'(k_r);
        out_ang_r  <= count_zero ? 16'sd0 : g_ang;
        out_dist_r <= count_zero ? 13'd0 : g_dist;
        out_ev_r   <= !count_zero;
        out_ovf_r  <= ovf_r;
        out_last_r <= sts.last_entry;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_ovf_r, out_dist_r, out_ang_r, out_idx_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_GROUPS)) else $error("group count beyond table depth");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT_LOAD && sts.last_entry) |=> (count_r == '0 && !ovf_r))
    else $error("table not cleared after final result");
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_EMIT_LOAD))
    else $error("result raised without a load");
endmodule

/* hdl/lane_segment_grouper_unit.sv */
// Top level of the lane segment grouper: controller plus datapath.
// Depends on lsg_pkg, lsg_ctrl, lsg_datapath (and lsg_ram through it).
//
//  channel | ports                         | payload
//  in      | in_tvalid/in_tready           | tuser: kind; tdata: start_x,start_y,end_x,end_y
//  out     | out_tvalid/out_tready         | tdata: entry_index,line_angle,line_distance,
//          |                               |   table_overflowed; tuser: entry_valid; tlast: last
//  cfg     | cfg_we, cfg_index, cfg_wdata  | img_width, img_height, angle_tolerance
//
// A segment runs through capture, prep, 6 product steps, the 20-step CORDIC with
// the 13-bit root search beside it, a latch of angle and distance, then a scan of
// the table entries on the table RAM read port.
// End of frame emits the table entries, held by any output stall; the last result waits
// in the output register while the next transaction is accepted.
// Reset is synchronous; the table needs no clearing pass.
module lane_segment_grouper_unit #(
  parameter int unsigned MAX_GROUPS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // start_x, start_y, end_x, end_y
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // entry_index, line_angle, line_distance, table_overflowed
  output logic        out_tuser,  // entry_valid
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import lsg_pkg::*;

  lsg_cmd_t    cmd;
  lsg_status_t sts;

  lsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsg_datapath #(.MAX_GROUPS(MAX_GROUPS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );
endmodule
